[sv/char_lcd_refresh_sequencer_macros.svh]
// Assertion helpers for the checker file of the LCD refresh sequencer.
`ifndef CHAR_LCD_REFRESH_SEQUENCER_MACROS_SVH
`define CHAR_LCD_REFRESH_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CRLS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("crls assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CRLS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("crls assertion failed");

`endif

[sv/crls_pkg.sv]
package crls_pkg;

  // Input command codes.
  typedef enum logic [1:0] {
    CMD_REFRESH = 2'd0,
    CMD_LOAD    = 2'd1,
    CMD_FINISH  = 2'd2
  } cmd_e;

  // Text store geometry: two lines at a fixed stride of sixteen columns.
  localparam int unsigned STRIDE = 16;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned ColW   = 5;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] ADDR_LINE0 = 8'h80;
  localparam logic [7:0] ADDR_LINE1 = 8'hC0;

  localparam logic [16:0] WAIT_NONE     = 17'd0;
  localparam logic [16:0] WAIT_POWER_UP = 17'd16000;
  localparam logic [16:0] WAIT_FS_2     = 17'd5000;
  localparam logic [16:0] WAIT_FS_3     = 17'd100000;
  localparam logic [10:0] WAIT_CMD      = 11'd40;
  localparam logic [10:0] WAIT_CLEAR    = 11'd1540;
  localparam logic [10:0] WAIT_CHAR     = 11'd1;

  // Greeting text; the first character sits in the top byte.
  localparam logic [255:0] GREETING = "Bem Vindo 57 123LCD ao Vindo Bem";

  // Write port of the text store.
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] addr;
    logic [7:0]       data;
  } store_wr_t;

  // Microcode.
  typedef logic [3:0] pc_t;

  localparam pc_t PC_FETCH = 4'd0;
  localparam pc_t PC_INIT0 = 4'd1;
  localparam pc_t PC_INIT1 = 4'd2;
  localparam pc_t PC_INIT2 = 4'd3;
  localparam pc_t PC_INIT3 = 4'd4;
  localparam pc_t PC_INIT4 = 4'd5;
  localparam pc_t PC_INIT5 = 4'd6;
  localparam pc_t PC_INIT6 = 4'd7;
  localparam pc_t PC_INIT7 = 4'd8;
  localparam pc_t PC_PREP  = 4'd9;
  localparam pc_t PC_CHAR  = 4'd10;
  localparam pc_t PC_ADDR  = 4'd11;
  localparam pc_t PC_LOAD  = 4'd12;
  localparam pc_t PC_PAD   = 4'd13;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_FETCH,
    ACT_INIT,
    ACT_READ,
    ACT_CHAR,
    ACT_ADDR,
    ACT_LOAD,
    ACT_PAD
  } act_e;

  typedef enum logic [1:0] {
    SRC_ROM,
    SRC_STORE,
    SRC_ADDR
  } src_e;

  typedef enum logic [2:0] {
    J_NEXT,
    J_GOTO,
    J_DISPATCH,
    J_COL_END,
    J_PAD
  } jmp_e;

  typedef struct packed {
    act_e        act;
    logic        emit;
    src_e        src;
    logic        rs;
    logic [7:0]  data_byte;
    logic [16:0] wait_pre;
    logic [10:0] wait_post;
    logic        last;
    jmp_e        jmp;
    pc_t         target;
  } uword_t;

  function automatic uword_t uw_init(logic [7:0] b, logic [16:0] bef, logic [10:0] aft);
    uword_t w;
    w           = '0;
    w.act       = ACT_NONE;
    w.emit      = 1'b1;
    w.src       = SRC_ROM;
    w.data_byte = b;
    w.wait_pre  = bef;
    w.wait_post = aft;
    w.jmp       = J_NEXT;
    return w;
  endfunction

  // Control store: one word per step.
  function automatic uword_t ucode(pc_t pc);
    uword_t w;
    w        = '0;
    w.act    = ACT_NONE;
    w.src    = SRC_ROM;
    w.jmp    = J_GOTO;
    w.target = PC_FETCH;
    unique case (pc)
      PC_FETCH: begin
        w.act = ACT_FETCH;
        w.jmp = J_DISPATCH;
      end
      PC_INIT0: w = uw_init(8'h38, WAIT_POWER_UP, WAIT_CMD);
      PC_INIT1: w = uw_init(8'h38, WAIT_FS_2, WAIT_CMD);
      PC_INIT2: w = uw_init(8'h38, WAIT_FS_3, WAIT_CMD);
      PC_INIT3: w = uw_init(8'h38, WAIT_NONE, WAIT_CMD);
      PC_INIT4: w = uw_init(8'h08, WAIT_NONE, WAIT_CMD);
      PC_INIT5: w = uw_init(8'h01, WAIT_NONE, WAIT_CLEAR);
      PC_INIT6: w = uw_init(8'h06, WAIT_NONE, WAIT_CMD);
      PC_INIT7: begin
        w        = uw_init(8'h0F, WAIT_NONE, WAIT_CMD);
        w.last   = 1'b1;
        w.act    = ACT_INIT;
        w.jmp    = J_GOTO;
        w.target = PC_FETCH;
      end
      PC_PREP: begin
        w.act    = ACT_READ;
        w.jmp    = J_COL_END;
        w.target = PC_ADDR;
      end
      PC_CHAR: begin
        w.act       = ACT_CHAR;
        w.emit      = 1'b1;
        w.src       = SRC_STORE;
        w.rs        = 1'b1;
        w.wait_post = WAIT_CHAR;
        w.last      = 1'b1;
      end
      PC_ADDR: begin
        w.act       = ACT_ADDR;
        w.emit      = 1'b1;
        w.src       = SRC_ADDR;
        w.wait_post = WAIT_CMD;
        w.last      = 1'b1;
      end
      PC_LOAD: w.act = ACT_LOAD;
      PC_PAD: begin
        w.act = ACT_PAD;
        w.jmp = J_PAD;
      end
      default: w.jmp = J_GOTO;
    endcase
    return w;
  endfunction

endpackage

[sv/crls_in_if.sv]
interface crls_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic       text_line;
  logic [7:0] text_char;

  modport source (output valid, cmd, text_line, text_char, input ready);
  modport sink   (input valid, cmd, text_line, text_char, output ready);
endinterface

[sv/crls_out_if.sv]
interface crls_out_if;
  logic        valid;
  logic        ready;
  logic        reg_select;
  logic [7:0]  bus_byte;
  logic [16:0] wait_before_us;
  logic [10:0] wait_after_us;
  logic        last;

  modport source (output valid, reg_select, bus_byte, wait_before_us, wait_after_us, last,
                  input ready);
  modport sink   (input valid, reg_select, bus_byte, wait_before_us, wait_after_us, last,
                  output ready);
endinterface

[sv/crls_text_store.sv]
module crls_text_store (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  crls_pkg::store_wr_t         wr_i,
  input  logic                        rd_en_i,
  input  logic [crls_pkg::AddrW-1:0]  rd_addr_i,
  output logic [7:0]                  rd_data_o
);
  import crls_pkg::*;

  localparam int unsigned Depth = 2 * STRIDE;

  logic [7:0] mem_q [Depth];
  logic [7:0] rd_data_q;

  // The store comes out of reset holding the greeting.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) begin
        mem_q[i] <= GREETING[8 * (Depth - 1 - i) +: 8];
      end
    end else if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
endmodule

[sv/char_lcd_refresh_sequencer.sv]
// Channel | Dir | Payload                                                   | Transfer
// in_i    | in  | cmd, text_line, text_char                                 | valid && ready
// out_o   | out | reg_select, bus_byte, wait_before_us, wait_after_us, last | valid && ready
//
// A refresh item runs the fetch, store read and emit steps; the first one after reset runs
// fetch and the init steps, which produce eight init writes. A load item runs fetch and
// load; a finish item runs fetch, then pads the line from the load column to its end, one
// store entry a cycle. The step counter runs one control word per cycle unless stalled.
// rst_ni is asynchronous and active low; it restores the greeting text and the init state.
// A held-up output register stalls only on an emitting step; other steps run on.
module char_lcd_refresh_sequencer #(
  parameter int unsigned COLUMNS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  crls_in_if.sink     in_i,
  crls_out_if.source  out_o
);
  import crls_pkg::*;

  // Refresh column counts 0..COLUMNS inclusive.
  localparam int unsigned RColW = $clog2(COLUMNS + 1);

  // Sequencer and display state.
  pc_t              pc_q, pc_d;
  logic             init_done_q;
  logic [RColW-1:0] refresh_col_q;
  logic             refresh_line_q;
  logic [ColW-1:0]  load_col_q;
  logic             line_q;
  logic [7:0]       char_q;

  // Output register.
  logic        out_valid_q;
  logic        out_rs_q;
  logic [7:0]  out_byte_q;
  logic [16:0] out_before_q;
  logic [10:0] out_after_q;
  logic        out_last_q;

  uword_t     uw;
  logic       out_free;
  logic       advance;
  logic       col_end;
  logic       load_room;
  logic       pad_room;
  logic [7:0] emit_byte;
  logic [7:0] rd_data;
  store_wr_t  store_wr;

  assign uw = ucode(pc_q);

  // An emitting step waits until the output register is free; the fetch step waits for
  // an input transfer. Every other step advances without waiting.
  assign out_free = !out_valid_q || out_o.ready;
  assign advance  = !((uw.emit && !out_free) || (uw.act == ACT_FETCH && !in_i.valid));

  assign in_i.ready = (uw.act == ACT_FETCH);

  assign col_end   = (refresh_col_q >= RColW'(COLUMNS));
  assign load_room = (load_col_q < ColW'(COLUMNS));
  assign pad_room  = (load_col_q < ColW'(STRIDE));

  // Next step. The dispatch jump decodes the command just taken in.
  always_comb begin
    pc_d = pc_q + 4'd1;
    unique case (uw.jmp)
      J_NEXT:    pc_d = pc_q + 4'd1;
      J_GOTO:    pc_d = uw.target;
      J_COL_END: pc_d = col_end ? uw.target : pc_q + 4'd1;
      J_PAD:     pc_d = pad_room ? pc_q : uw.target;
      J_DISPATCH: begin
        unique case (in_i.cmd)
          CMD_REFRESH: pc_d = init_done_q ? PC_PREP : PC_INIT0;
          CMD_LOAD:    pc_d = PC_LOAD;
          CMD_FINISH:  pc_d = PC_PAD;
          default:     pc_d = PC_FETCH;
        endcase
      end
      default:   pc_d = PC_FETCH;
    endcase
  end

  // Byte selection for the emitting steps. The set-address command names the line that
  // is about to be written, which is the opposite of the current one.
  always_comb begin
    unique case (uw.src)
      SRC_ROM:   emit_byte = uw.data_byte;
      SRC_STORE: emit_byte = rd_data;
      SRC_ADDR:  emit_byte = refresh_line_q ? ADDR_LINE0 : ADDR_LINE1;
      default:   emit_byte = uw.data_byte;
    endcase
  end

  // Store writes: one character per load and one space per pad cycle, while the line has room.
  always_comb begin
    store_wr.addr = {line_q, load_col_q[AddrW-2:0]};
    store_wr.data = (uw.act == ACT_LOAD) ? char_q : CHAR_SPACE;
    store_wr.we   = ((uw.act == ACT_LOAD) && load_room) || ((uw.act == ACT_PAD) && pad_room);
  end

  crls_text_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (store_wr),
    .rd_en_i   (uw.act == ACT_READ),
    .rd_addr_i ({refresh_line_q, refresh_col_q[AddrW-2:0]}),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q           <= PC_FETCH;
      init_done_q    <= 1'b0;
      refresh_col_q  <= '0;
      refresh_line_q <= 1'b0;
      load_col_q     <= '0;
      line_q         <= 1'b0;
      char_q         <= '0;
      out_valid_q    <= 1'b0;
      out_rs_q       <= 1'b0;
      out_byte_q     <= '0;
      out_before_q   <= '0;
      out_after_q    <= '0;
      out_last_q     <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (advance) begin
        pc_q <= pc_d;
        if (uw.emit) begin
          out_valid_q  <= 1'b1;
          out_rs_q     <= uw.rs;
          out_byte_q   <= emit_byte;
          out_before_q <= uw.wait_pre;
          out_after_q  <= uw.wait_post;
          out_last_q   <= uw.last;
        end
        unique case (uw.act)
          ACT_FETCH: begin
            line_q <= in_i.text_line;
            char_q <= in_i.text_char;
          end
          ACT_INIT: init_done_q <= 1'b1;
          ACT_CHAR: refresh_col_q <= refresh_col_q + 1'b1;
          ACT_ADDR: begin
            refresh_col_q  <= '0;
            refresh_line_q <= ~refresh_line_q;
          end
          ACT_LOAD: begin
            if (load_room) begin
              load_col_q <= load_col_q + 1'b1;
            end
          end
          ACT_PAD: begin
            if (pad_room) begin
              load_col_q <= load_col_q + 1'b1;
            end else begin
              load_col_q <= '0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.reg_select     = out_rs_q;
  assign out_o.bus_byte       = out_byte_q;
  assign out_o.wait_before_us = out_before_q;
  assign out_o.wait_after_us  = out_after_q;
  assign out_o.last           = out_last_q;
endmodule

[sv/crls_checker.sv]
`include "char_lcd_refresh_sequencer_macros.svh"

module crls_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic [1:0]  in_cmd_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        out_reg_select_i,
  input logic [7:0]  out_bus_byte_i,
  input logic [16:0] out_wait_before_i,
  input logic [10:0] out_wait_after_i,
  input logic        out_last_i
);
  import crls_pkg::*;

  logic [37:0] out_payload;
  logic        out_stall;
  logic        in_take;
  logic        char_ok;
  logic        pre_wait;
  logic        cmd_not_last;

  assign out_payload  = {out_reg_select_i, out_bus_byte_i, out_wait_before_i,
                         out_wait_after_i, out_last_i};
  assign out_stall    = out_valid_i && !out_ready_i;
  // The unused command code returns to the fetch step at once, so it is left out.
  assign in_take      = in_valid_i && in_ready_i &&
                        ((in_cmd_i == CMD_REFRESH) || (in_cmd_i == CMD_LOAD) ||
                         (in_cmd_i == CMD_FINISH));
  assign char_ok      = (out_wait_after_i == WAIT_CHAR) && (out_wait_before_i == WAIT_NONE) &&
                        out_last_i;
  assign pre_wait     = (out_wait_before_i != WAIT_NONE);
  assign cmd_not_last = !out_reg_select_i && !out_last_i;

  // A stalled result keeps its contents.
  `CRLS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_i && $stable(out_payload))

  // After taking a known command the sequencer is not ready in the next cycle.
  `CRLS_ASSERT_NXT(a_busy_after_take, clk_i, rst_ni, in_take, !in_ready_i)

  // Character writes carry the short wait and always close their item.
  `CRLS_ASSERT_IMP(a_char_write, clk_i, rst_ni, out_valid_i && out_reg_select_i, char_ok)

  // Only early init writes wait beforehand, and none of them ends an item.
  `CRLS_ASSERT_IMP(a_pre_wait, clk_i, rst_ni, out_valid_i && pre_wait, cmd_not_last)
endmodule

bind char_lcd_refresh_sequencer crls_checker u_crls_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .in_cmd_i          (in_i.cmd),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_reg_select_i  (out_o.reg_select),
  .out_bus_byte_i    (out_o.bus_byte),
  .out_wait_before_i (out_o.wait_before_us),
  .out_wait_after_i  (out_o.wait_after_us),
  .out_last_i        (out_o.last)
);

[verif/crls_bus_check.sv]
`timescale 1ns / 1ps

// Watches both channels of the LCD refresh sequencer, keeps its own copy of
// the text store and refresh position, and checks every bus write transfer.
module crls_bus_check
  import crls_pkg::*;
#(
  parameter int unsigned COLUMNS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  crls_in_if          in_i,
  crls_out_if         out_i,
  output int unsigned errors_o,
  output int unsigned pending_o,
  output int unsigned items_o,
  output int unsigned writes_o
);

  // HD44780 command bytes used by the power-up sequence.
  localparam logic [7:0] LCD_FUNC_SET = 8'h38;
  localparam logic [7:0] LCD_DISP_OFF = 8'h08;
  localparam logic [7:0] LCD_CLEAR    = 8'h01;
  localparam logic [7:0] LCD_ENTRY    = 8'h06;
  localparam logic [7:0] LCD_DISP_ON  = 8'h0F;
  localparam int unsigned REPORT_MAX  = 10;

  typedef struct packed {
    logic        rs;
    logic [7:0]  data;
    logic [16:0] wait_pre;
    logic [10:0] wait_post;
    logic        last;
  } bus_write_t;

  logic [7:0] screen_text [32];
  logic [4:0] draw_col;
  logic       draw_line;
  logic [4:0] fill_col;
  logic       powered_up;
  bus_write_t bus_writes_due [$];

  function automatic bus_write_t power_up_write(int unsigned step);
    bus_write_t w;
    w           = '0;
    w.wait_pre  = WAIT_NONE;
    w.wait_post = WAIT_CMD;
    w.last      = (step == 7);
    case (step)
      0: begin
        w.data     = LCD_FUNC_SET;
        w.wait_pre = WAIT_POWER_UP;
      end
      1: begin
        w.data     = LCD_FUNC_SET;
        w.wait_pre = WAIT_FS_2;
      end
      2: begin
        w.data     = LCD_FUNC_SET;
        w.wait_pre = WAIT_FS_3;
      end
      3: w.data = LCD_FUNC_SET;
      4: w.data = LCD_DISP_OFF;
      5: begin
        w.data      = LCD_CLEAR;
        w.wait_post = WAIT_CLEAR;
      end
      6: w.data = LCD_ENTRY;
      default: w.data = LCD_DISP_ON;
    endcase
    return w;
  endfunction

  task automatic clear_model();
    for (int i = 0; i < 32; i++) begin
      screen_text[i] = GREETING[255 - 8 * i -: 8];
    end
    draw_col   = '0;
    draw_line  = 1'b0;
    fill_col   = '0;
    powered_up = 1'b0;
    bus_writes_due.delete();
  endtask

  // Works out the bus writes that one accepted item causes and updates the
  // copy of the block's state.
  task automatic predict_item(logic [1:0] code, logic text_line, logic [7:0] text_char);
    bus_write_t w;
    case (code)
      CMD_REFRESH: begin
        if (!powered_up) begin
          // The first refresh only powers the display up; position stays put.
          for (int k = 0; k < 8; k++) begin
            bus_writes_due.push_back(power_up_write(k));
          end
          powered_up = 1'b1;
        end else if (draw_col < COLUMNS) begin
          w.rs        = 1'b1;
          w.data      = screen_text[{draw_line, draw_col[3:0]}];
          w.wait_pre  = WAIT_NONE;
          w.wait_post = WAIT_CHAR;
          w.last      = 1'b1;
          bus_writes_due.push_back(w);
          draw_col = draw_col + 5'd1;
        end else begin
          draw_col    = '0;
          draw_line   = ~draw_line;
          w.rs        = 1'b0;
          w.data      = draw_line ? ADDR_LINE1 : ADDR_LINE0;
          w.wait_pre  = WAIT_NONE;
          w.wait_post = WAIT_CMD;
          w.last      = 1'b1;
          bus_writes_due.push_back(w);
        end
      end
      CMD_LOAD: begin
        if (fill_col < COLUMNS) begin
          screen_text[{text_line, fill_col[3:0]}] = text_char;
          fill_col = fill_col + 5'd1;
        end
      end
      CMD_FINISH: begin
        for (int c = fill_col; c < STRIDE; c++) begin
          screen_text[{text_line, c[3:0]}] = CHAR_SPACE;
        end
        fill_col = '0;
      end
      default: ;
    endcase
  endtask

  task automatic check_write();
    bus_write_t got;
    bus_write_t want;
    got.rs        = out_i.reg_select;
    got.data      = out_i.bus_byte;
    got.wait_pre  = out_i.wait_before_us;
    got.wait_post = out_i.wait_after_us;
    got.last      = out_i.last;
    writes_o      = writes_o + 1;
    if (bus_writes_due.size() == 0) begin
      errors_o = errors_o + 1;
      if (errors_o <= REPORT_MAX) begin
        $display("[%0t] unexpected bus write: rs %0d byte %02h before %0d after %0d last %0d",
                 $time, got.rs, got.data, got.wait_pre, got.wait_post, got.last);
      end
    end else begin
      want = bus_writes_due.pop_front();
      if (got.rs !== want.rs || got.data !== want.data || got.wait_pre !== want.wait_pre ||
          got.wait_post !== want.wait_post || got.last !== want.last) begin
        errors_o = errors_o + 1;
        if (errors_o <= REPORT_MAX) begin
          $display("[%0t] bus write mismatch: rs %0d/%0d byte %02h/%02h before %0d/%0d",
                   $time, want.rs, got.rs, want.data, got.data, want.wait_pre, got.wait_pre);
          $display("    after %0d/%0d last %0d/%0d (expected/actual)",
                   want.wait_post, got.wait_post, want.last, got.last);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_model();
      errors_o  <= 0;
      pending_o <= 0;
      items_o   <= 0;
      writes_o  <= 0;
    end else begin
      // An output transfer never belongs to an input taken at the same edge.
      if (out_i.valid && out_i.ready) begin
        check_write();
      end
      if (in_i.valid && in_i.ready) begin
        items_o = items_o + 1;
        predict_item(in_i.cmd, in_i.text_line, in_i.text_char);
      end
      pending_o <= bus_writes_due.size();
    end
  end

endmodule

[verif/char_lcd_refresh_sequencer_test.sv]
`timescale 1ns / 1ps

// Top of the testbench for the character LCD refresh sequencer. It makes the
// clock and reset, drives the item channel in bursts, stalls the bus write
// channel, and gives the verdict from the counts that crls_bus_check returns.
module char_lcd_refresh_sequencer_test;
  import crls_pkg::*;

  localparam int unsigned COLUMNS      = 16;
  // The unused command code, which the block must ignore.
  localparam logic [1:0]  CMD_UNUSED   = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 145;
  // Cycles without any transfer before the run is declared hung. The longest
  // honest quiet spell is a finish item or a sender gap.
  localparam int unsigned STALL_LIMIT  = 2000;
  // Quiet cycles at the end, so that a stray write would still be seen.
  localparam int unsigned DRAIN_CYCLES = 40;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  crls_in_if  in_if ();
  crls_out_if out_if ();

  int unsigned errors;
  int unsigned pending;
  int unsigned items;
  int unsigned writes;

  int unsigned burst_left   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned ready_phase  = 0;
  int unsigned refresh_sent = 0;
  int unsigned load_sent    = 0;
  int unsigned finish_sent  = 0;
  int unsigned unused_sent  = 0;

  char_lcd_refresh_sequencer #(
    .COLUMNS (COLUMNS)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  crls_bus_check #(
    .COLUMNS (COLUMNS)
  ) bus_check (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_if),
    .out_i     (out_if),
    .errors_o  (errors),
    .pending_o (pending),
    .items_o   (items),
    .writes_o  (writes)
  );

  always #2 clk_i = ~clk_i;

  // The receiver cycles through four stall patterns of equal length: always
  // ready, a coin flip, ready one cycle in five, and ready three times in four.
  // That way stalls land on refresh writes; the init burst falls in the always-ready spell.
  always @(posedge clk_i) begin
    ready_phase <= ready_phase + 1;
    case ((ready_phase / 48) % 4)
      0: out_if.ready <= 1'b1;
      1: out_if.ready <= 1'($urandom_range(0, 1));
      2: out_if.ready <= (ready_phase % 5 == 0);
      default: out_if.ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Watchdog: any transfer on either channel restarts the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Sends one item and returns at the edge where it is transferred. Between
  // bursts the sender drops valid for a random gap; now and then a burst is
  // long, which gives stretches with no idling at all.
  task automatic send_item(logic [1:0] code, logic text_line, logic [7:0] text_char);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
    end
    in_if.valid     <= 1'b1;
    in_if.cmd       <= code;
    in_if.text_line <= text_line;
    in_if.text_char <= text_char;
    do @(posedge clk_i); while (!in_if.ready);
    burst_left = burst_left - 1;
    case (code)
      CMD_REFRESH: refresh_sent++;
      CMD_LOAD:    load_sent++;
      CMD_FINISH:  finish_sent++;
      default:     unused_sent++;
    endcase
  endtask

  initial begin
    int unsigned counted;
    int unsigned pick;
    int unsigned run;
    int unsigned text_len;
    logic        line_sel;

    in_if.valid     = 1'b0;
    in_if.cmd       = CMD_REFRESH;
    in_if.text_line = 1'b0;
    in_if.text_char = 8'h00;
    out_if.ready    = 1'b0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. The first refresh gives the power-up burst, the second
    // the first greeting character.
    send_item(CMD_REFRESH, 1'b0, 8'h00);
    send_item(CMD_REFRESH, 1'b1, 8'hFF);
    // The load column is shared: consecutive loads may name different lines.
    send_item(CMD_LOAD, 1'b0, 8'h00);
    send_item(CMD_LOAD, 1'b1, 8'hFF);
    send_item(CMD_UNUSED, 1'b1, 8'hAA);
    // Pads line 1 from column 2 onward.
    send_item(CMD_FINISH, 1'b1, 8'h55);
    send_item(CMD_REFRESH, 1'b0, 8'h00);
    // A full line of text, then one character too many, which is dropped.
    // The codes step by 0x11, so every data bit is set and cleared.
    for (int k = 0; k < 16; k++) begin
      send_item(CMD_LOAD, 1'b0, 8'(k * 17));
    end
    send_item(CMD_LOAD, 1'b0, 8'h5A);
    // Finish with the load column already at the end pads nothing.
    send_item(CMD_FINISH, 1'b0, 8'h00);

    // Random part: mostly runs of refresh steps long enough to wrap the
    // lines, and well-formed text loads. Some loads overrun the line, some
    // are left unfinished or stray onto the other line, and a few items use
    // the unused code.
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        run = $urandom_range(1, 40);
        if (run > RANDOM_ITEMS - counted) begin
          run = RANDOM_ITEMS - counted;
        end
        repeat (run) begin
          send_item(CMD_REFRESH, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        end
        counted += run;
      end else if (pick < 85) begin
        line_sel = 1'($urandom_range(0, 1));
        text_len = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 20)
                                               : $urandom_range(1, 16);
        for (int k = 0; k < text_len; k++) begin
          send_item(CMD_LOAD, ($urandom_range(0, 9) == 0) ? ~line_sel : line_sel,
                    8'($urandom_range(0, 255)));
        end
        counted += text_len;
        if ($urandom_range(0, 4) != 0) begin
          send_item(CMD_FINISH, line_sel, 8'($urandom_range(0, 255)));
          counted++;
        end
      end else if (pick < 93) begin
        send_item(CMD_FINISH, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        counted++;
      end else begin
        send_item(CMD_UNUSED, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        counted++;
      end
    end
    in_if.valid <= 1'b0;

    // Let the monitor settle on the last edge, then wait for every write.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Coverage: %0d refresh, %0d load, %0d finish and %0d unused-code items sent",
             refresh_sent, load_sent, finish_sent, unused_sent);
    $display("Coverage: %0d item transfers seen, %0d bus write transfers checked",
             items, writes);
    if (errors == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
